>>> rtl/conv2d_clamp_edge_rgb_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef CONV2D_CLAMP_EDGE_RGB_UNIT_MACROS_SVH
`define CONV2D_CLAMP_EDGE_RGB_UNIT_MACROS_SVH
// Assert that a condition implies a property in the same cycle.
`define C2D_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Assert that a condition implies a property in the next cycle.
`define C2D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> rtl/c2d_pkg.sv
`default_nettype none
package c2d_pkg;
    typedef enum logic [1:0] {
        CMD_WR_PIX  = 2'd0,
        CMD_WR_COEF = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_RAD_X  = 2'd2,
        REG_RAD_Y  = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } t_state;

    localparam int PIX_MAX = 255;

    // one request as handed from front to back
    typedef struct packed {
        t_cmd        cmd;
        logic [8:0]  pos_x;
        logic [8:0]  pos_y;
        logic [23:0] rgb;
        logic [7:0]  coef_index;
        logic [15:0] coef_value;
    } t_req;
endpackage
`default_nettype wire

>>> rtl/c2d_ram.sv
`default_nettype none
module c2d_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 262144
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/c2d_front.sv
`default_nettype none
module c2d_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  c2d_pkg::t_req     i_req,
    output logic              o_valid,
    input  wire               i_ready,
    output c2d_pkg::t_req     o_req
);
    // two-entry queue; command 3 is dropped here
    c2d_pkg::t_req r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign push    = i_valid && o_ready && (i_req.cmd != c2d_pkg::CMD_NONE);
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_req   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_req;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

>>> rtl/c2d_back.sv
`default_nettype none
module c2d_back #(
    parameter int MAX_WIDTH      = 512,
    parameter int MAX_HEIGHT     = 512,
    parameter int MAX_TAPS_SIDE  = 15,
    parameter int COEF_FRAC_BITS = 11
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    output logic          o_ready,
    input  c2d_pkg::t_req i_req,
    input  wire [9:0]     i_width,
    input  wire [9:0]     i_height,
    input  wire [2:0]     i_rad_x,
    input  wire [2:0]     i_rad_y,
    output logic          o_valid,
    input  wire           i_ready,
    output logic [23:0]   o_rgb
);
    localparam int XW    = $clog2(MAX_WIDTH) > 0 ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = $clog2(MAX_HEIGHT) > 0 ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW    = XW + YW;
    localparam int CDEP  = MAX_TAPS_SIDE * MAX_TAPS_SIDE;
    localparam int CW    = $clog2(CDEP) > 0 ? $clog2(CDEP) : 1;
    localparam int MAXR  = (MAX_TAPS_SIDE - 1) / 2;
    localparam int ACCW  = 8 + 16 + 2 * CW + 2;
    localparam int CRW   = 13;

    c2d_pkg::t_state r_state, n_state;

    // coefficient memory with one written flag per tap
    logic [CDEP-1:0]       r_cvld;
    logic                  r_cv;
    logic [15:0]           coef_rdata;
    logic signed [15:0]    wgt;
    logic                  coef_we;

    // window walk
    logic signed [CRW-1:0] r_kx, r_ky, r_rx, r_ry;
    logic signed [CRW-1:0] r_px, r_py, r_wtop, r_htop;
    logic [CW-1:0]         r_ti;
    logic                  r_rd_v, r_rd_v2;
    logic signed [ACCW-1:0] r_acc [3];
    logic signed [ACCW-1:0] r_prod [3];
    logic [23:0]           r_out;
    logic [AW-1:0]         rd_addr;
    logic [23:0]           rd_data;
    logic                  pix_we;
    logic                  last_tap;
    logic signed [CRW-1:0] nx, ny, sx, sy;

    // effective frame and radius
    logic [12:0] wsat, hsat;
    logic [2:0]  rxs, rys;
    always_comb begin
        wsat = (i_width == 10'd0) ? 13'd1 :
               ({3'd0, i_width} > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : {3'd0, i_width};
        hsat = (i_height == 10'd0) ? 13'd1 :
               ({3'd0, i_height} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : {3'd0, i_height};
        rxs  = (int'(i_rad_x) > MAXR) ? 3'(MAXR) : i_rad_x;
        rys  = (int'(i_rad_y) > MAXR) ? 3'(MAXR) : i_rad_y;
    end

    // clamp the current neighbor
    always_comb begin
        sx = r_px + r_kx;
        sy = r_py + r_ky;
        nx = (sx < 0) ? '0 : (sx > r_wtop) ? r_wtop : sx;
        ny = (sy < 0) ? '0 : (sy > r_htop) ? r_htop : sy;
        rd_addr  = {ny[YW-1:0], nx[XW-1:0]};
        last_tap = (r_kx == r_rx) && (r_ky == r_ry);
    end

    assign pix_we = (r_state == c2d_pkg::ST_IDLE) && i_valid &&
                    (i_req.cmd == c2d_pkg::CMD_WR_PIX) &&
                    (int'(i_req.pos_x) < MAX_WIDTH) && (int'(i_req.pos_y) < MAX_HEIGHT);

    c2d_ram #(.WIDTH(24), .DEPTH(1 << AW)) u_frame (
        .i_clk  (i_clk),
        .i_we   (pix_we),
        .i_waddr({YW'(i_req.pos_y), XW'(i_req.pos_x)}),
        .i_wdata(i_req.rgb),
        .i_raddr(rd_addr),
        .o_rdata(rd_data)
    );

    assign coef_we = (r_state == c2d_pkg::ST_IDLE) && i_valid &&
                     (i_req.cmd == c2d_pkg::CMD_WR_COEF) &&
                     (int'(i_req.coef_index) < CDEP);

    c2d_ram #(.WIDTH(16), .DEPTH(CDEP)) u_coef (
        .i_clk  (i_clk),
        .i_we   (coef_we),
        .i_waddr(CW'(i_req.coef_index)),
        .i_wdata(i_req.coef_value),
        .i_raddr(r_ti),
        .o_rdata(coef_rdata)
    );

    // unwritten taps weigh zero
    assign wgt = r_cv ? $signed(coef_rdata) : 16'sd0;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            c2d_pkg::ST_IDLE:
                if (i_valid && i_req.cmd == c2d_pkg::CMD_COMPUTE) n_state = c2d_pkg::ST_RUN;
            c2d_pkg::ST_RUN:   if (last_tap) n_state = c2d_pkg::ST_DRAIN;
            c2d_pkg::ST_DRAIN: if (!r_rd_v && !r_rd_v2) n_state = c2d_pkg::ST_OUT;
            c2d_pkg::ST_OUT:   if (i_ready) n_state = c2d_pkg::ST_IDLE;
            default:           n_state = c2d_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready = (r_state == c2d_pkg::ST_IDLE);
        o_valid = (r_state == c2d_pkg::ST_OUT);
    end
    assign o_rgb = r_out;

    // saturate one channel
    function automatic logic [7:0] fin(input logic signed [ACCW-1:0] s);
        logic signed [ACCW-1:0] q;
        begin
            q = s >>> COEF_FRAC_BITS;
            if (s < 0) fin = 8'd0;
            else if (q > ACCW'(c2d_pkg::PIX_MAX)) fin = 8'(c2d_pkg::PIX_MAX);
            else fin = q[7:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        // mark written taps
        if (!i_rst_n) begin
            r_cvld <= '0;
        end else if (coef_we) begin
            r_cvld[CW'(i_req.coef_index)] <= 1'b1;
        end
        r_cv <= r_cvld[r_ti];

        if (!i_rst_n) begin
            r_state <= c2d_pkg::ST_IDLE;
            r_rd_v  <= 1'b0;
            r_rd_v2 <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= (r_state == c2d_pkg::ST_RUN);
            r_rd_v2 <= r_rd_v;
        end

        // start a window
        if (r_state == c2d_pkg::ST_IDLE) begin
            r_px   <= CRW'(i_req.pos_x);
            r_py   <= CRW'(i_req.pos_y);
            r_wtop <= CRW'(wsat) - 13'd1;
            r_htop <= CRW'(hsat) - 13'd1;
            r_rx   <= CRW'(rxs);
            r_ry   <= CRW'(rys);
            r_kx   <= -CRW'(rxs);
            r_ky   <= -CRW'(rys);
            r_ti   <= '0;
            for (int c = 0; c < 3; c++) r_acc[c] <= '0;
        end else if (r_state == c2d_pkg::ST_RUN) begin
            if (r_kx == r_rx) begin
                r_kx <= -r_rx;
                r_ky <= r_ky + 13'sd1;
            end else begin
                r_kx <= r_kx + 13'sd1;
            end
            r_ti <= r_ti + 1'b1;
        end

        // multiply stage then accumulate
        if (r_rd_v) begin
            for (int c = 0; c < 3; c++)
                r_prod[c] <= ACCW'($signed({1'b0, rd_data[8*c +: 8]}) * wgt);
        end
        if (r_rd_v2) begin
            for (int c = 0; c < 3; c++) r_acc[c] <= r_acc[c] + r_prod[c];
        end
        if (r_state == c2d_pkg::ST_DRAIN && !r_rd_v && !r_rd_v2)
            r_out <= {fin(r_acc[2]), fin(r_acc[1]), fin(r_acc[0])};
    end
endmodule
`default_nettype wire

>>> rtl/conv2d_clamp_edge_rgb_unit.sv
`default_nettype none
// RGB 2D convolution with edge replication over a frame memory. Pixel and
// coefficient writes are taken by the back end while it is idle; a compute
// request walks its (2rx+1)x(2ry+1) window one frame-memory read per cycle,
// then the products are summed and the result is held until it is taken.
// A two-entry queue in front accepts requests while the back end works.
module conv2d_clamp_edge_rgb_unit #(
    parameter int MAX_WIDTH      = 512,
    parameter int MAX_HEIGHT     = 512,
    parameter int MAX_TAPS_SIDE  = 15,
    parameter int COEF_FRAC_BITS = 11
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // command[1:0]
    input  wire [1:0]   s_axis_tuser,
    // pos_x[8:0] pos_y[17:9] red[25:18] green[33:26] blue[41:34]
    // coef_index[49:42] coef_value[65:50], zero [71:66]
    input  wire [71:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // red[7:0] green[15:8] blue[23:16]
    output logic [23:0] m_axis_tdata,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [1:0]   i_cfg_index,
    input  wire [9:0]   i_cfg_data
);
    logic [9:0] r_width, r_height;
    logic [2:0] r_rad_x, r_rad_y;
    c2d_pkg::t_req in_req, q_req;
    logic q_valid, q_ready;

    assign o_cfg_ready = 1'b1;
    // hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 10'd512; r_height <= 10'd512; r_rad_x <= 3'd1; r_rad_y <= 3'd1;
        end else if (i_cfg_valid) begin
            unique case (c2d_pkg::t_reg'(i_cfg_index))
                c2d_pkg::REG_WIDTH:  r_width  <= i_cfg_data;
                c2d_pkg::REG_HEIGHT: r_height <= i_cfg_data;
                c2d_pkg::REG_RAD_X:  r_rad_x  <= i_cfg_data[2:0];
                c2d_pkg::REG_RAD_Y:  r_rad_y  <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        in_req.cmd        = c2d_pkg::t_cmd'(s_axis_tuser);
        in_req.pos_x      = s_axis_tdata[8:0];
        in_req.pos_y      = s_axis_tdata[17:9];
        in_req.rgb        = {s_axis_tdata[41:34], s_axis_tdata[33:26], s_axis_tdata[25:18]};
        in_req.coef_index = s_axis_tdata[49:42];
        in_req.coef_value = s_axis_tdata[65:50];
    end

    c2d_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_req(in_req),
        .o_valid(q_valid), .i_ready(q_ready), .o_req(q_req)
    );

    c2d_back #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_TAPS_SIDE(MAX_TAPS_SIDE), .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_req(q_req),
        .i_width(r_width), .i_height(r_height), .i_rad_x(r_rad_x), .i_rad_y(r_rad_y),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_rgb(m_axis_tdata)
    );
endmodule
`default_nettype wire

>>> rtl/c2d_checker.sv
`default_nettype none
`include "conv2d_clamp_edge_rgb_unit_macros.svh"
module c2d_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [23:0] m_axis_tdata
);
    // a waiting result holds its data
    `C2D_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && m_axis_tvalid)
    // a result is never offered in the cycle right after one was taken
    `C2D_ASSERT_NEXT(a_gap, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready, !m_axis_tvalid)
    // output is quiet in the first cycle seen out of reset
    `C2D_ASSERT_IMP(a_nofirst, i_clk, i_rst_n, $rose(i_rst_n), !m_axis_tvalid)
    // the empty queue takes a request right after reset
    `C2D_ASSERT_IMP(a_rdy_first, i_clk, i_rst_n, $rose(i_rst_n), s_axis_tready)
endmodule
bind conv2d_clamp_edge_rgb_unit c2d_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
